### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TSMD_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define TSMD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tsmd_pkg.sv
`default_nettype none

package tsmd_pkg;

    localparam int FIELD_BUFFER_BYTES_DEF = 16;

    localparam int BYTE_W = 8;
    localparam int MARK_W = 2;
    localparam int PAY_W  = 6;

    localparam logic [MARK_W-1:0] MARK_NONE = 2'b00;
    localparam int END_FIELD_BIT = 0;
    localparam int END_MSG_BIT   = 1;

    localparam logic [PAY_W-1:0] CODE_DAQ = 6'd7;

    localparam int SRC_BITS_W = 5;
    localparam logic [SRC_BITS_W-1:0] SRC_MAX = 5'd16;

    localparam int SRC_W   = 16;
    localparam int TAG_W   = 64;
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 64;

    // Only the low SRC_W + TAG_W bits of a field are ever looked at.
    localparam int KEEP_CHUNKS = (SRC_W + TAG_W + PAY_W - 1) / PAY_W;
    localparam int WIN_BITS    = KEEP_CHUNKS * PAY_W;

    localparam int FIDX_W = 3;
    localparam logic [FIDX_W-1:0] FIELD_SRC   = 3'd0;
    localparam logic [FIDX_W-1:0] FIELD_DATA  = 3'd1;
    localparam logic [FIDX_W-1:0] FIELD_STAMP = 3'd2;
    localparam logic [FIDX_W-1:0] FIELD_LAST  = 3'd3;
    localparam logic [FIDX_W-1:0] FIELD_MAX   = 3'd7;

    typedef struct packed {
        logic                ovf;
        logic [WIN_BITS-1:0] bits;
    } field_t;

endpackage

`default_nettype wire

### rtl/tsmd_field_buf.sv
`default_nettype none

module tsmd_field_buf #(
    parameter int FIELD_BUFFER_BYTES = tsmd_pkg::FIELD_BUFFER_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         beat,
    input  wire logic                         msg_open,
    input  wire logic [tsmd_pkg::BYTE_W-1:0]  slice,
    output tsmd_pkg::field_t                  field
);

    localparam int SLOTS = (FIELD_BUFFER_BYTES * 8 - 1) / tsmd_pkg::PAY_W;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           ovf_reg, ovf_next;
    logic [tsmd_pkg::PAY_W-1:0]     chunk_reg  [tsmd_pkg::KEEP_CHUNKS];
    logic [tsmd_pkg::PAY_W-1:0]     chunk_next [tsmd_pkg::KEEP_CHUNKS];
    logic [tsmd_pkg::MARK_W-1:0]    marker;
    logic [tsmd_pkg::PAY_W-1:0]     pay;
    logic                           append;

    assign marker = slice[tsmd_pkg::MARK_W-1:0];
    assign pay    = slice[tsmd_pkg::BYTE_W-1:tsmd_pkg::MARK_W];
    assign append = (cnt_reg < SLOTS_C);

    // Field as it stands with this beat's chunk included.
    always_comb
    begin
        field.ovf = ovf_reg | ~append;
        for (int i = 0; i < tsmd_pkg::KEEP_CHUNKS; i++)
        begin
            if (append && cnt_reg == CNT_W'(i))
            begin
                field.bits[i*tsmd_pkg::PAY_W +: tsmd_pkg::PAY_W] = pay;
            end
            else
            begin
                field.bits[i*tsmd_pkg::PAY_W +: tsmd_pkg::PAY_W] = chunk_reg[i];
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        for (int i = 0; i < tsmd_pkg::KEEP_CHUNKS; i++)
        begin
            chunk_next[i] = chunk_reg[i];
        end
        if (beat && msg_open)
        begin
            if (marker != tsmd_pkg::MARK_NONE)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
                for (int i = 0; i < tsmd_pkg::KEEP_CHUNKS; i++)
                begin
                    chunk_next[i] = '0;
                end
            end
            else
            begin
                ovf_next = field.ovf;
                if (append)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                for (int i = 0; i < tsmd_pkg::KEEP_CHUNKS; i++)
                begin
                    chunk_next[i] = field.bits[i*tsmd_pkg::PAY_W +: tsmd_pkg::PAY_W];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            for (int i = 0; i < tsmd_pkg::KEEP_CHUNKS; i++)
            begin
                chunk_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            for (int i = 0; i < tsmd_pkg::KEEP_CHUNKS; i++)
            begin
                chunk_reg[i] <= chunk_next[i];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/tsmd_msg_ctrl.sv
`default_nettype none

module tsmd_msg_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            beat,
    input  wire logic [tsmd_pkg::BYTE_W-1:0]     slice,
    input  wire tsmd_pkg::field_t                field,
    input  wire logic [tsmd_pkg::SRC_BITS_W-1:0] src_bits,
    input  wire logic                            res_take,
    output logic                                 msg_open,
    output logic                                 res_valid,
    output logic                                 res_src_vld,
    output logic [tsmd_pkg::SRC_W-1:0]           res_src,
    output logic [tsmd_pkg::TAG_W-1:0]           res_tag,
    output logic [tsmd_pkg::DATA_W-1:0]          res_data,
    output logic                                 res_stamp_vld,
    output logic [tsmd_pkg::STAMP_W-1:0]         res_stamp
);

    logic [tsmd_pkg::MARK_W-1:0]     marker;
    logic [tsmd_pkg::PAY_W-1:0]      pay;
    logic [tsmd_pkg::SRC_BITS_W-1:0] sb;
    logic [tsmd_pkg::SRC_W:0]        src_mask;
    logic [tsmd_pkg::WIN_BITS-1:0]   shifted;
    logic [tsmd_pkg::SRC_W-1:0]      src_val;

    logic                            open_reg, open_next;
    logic                            acc_reg, acc_next;
    logic [tsmd_pkg::FIDX_W-1:0]     fidx_reg, fidx_next;
    logic                            movf_reg, movf_next;
    logic [1:0]                      flags_reg, flags_next;
    logic [tsmd_pkg::SRC_W-1:0]      src_reg, src_next;
    logic [tsmd_pkg::TAG_W-1:0]      tag_reg, tag_next;
    logic [tsmd_pkg::DATA_W-1:0]     data_reg, data_next;
    logic [tsmd_pkg::STAMP_W-1:0]    stamp_reg, stamp_next;
    logic                            emit;

    logic                            rv_reg, rv_next;
    logic                            r_src_vld_reg;
    logic [tsmd_pkg::SRC_W-1:0]      r_src_reg;
    logic [tsmd_pkg::TAG_W-1:0]      r_tag_reg;
    logic [tsmd_pkg::DATA_W-1:0]     r_data_reg;
    logic                            r_stamp_vld_reg;
    logic [tsmd_pkg::STAMP_W-1:0]    r_stamp_reg;

    assign marker = slice[tsmd_pkg::MARK_W-1:0];
    assign pay    = slice[tsmd_pkg::BYTE_W-1:tsmd_pkg::MARK_W];

    assign sb       = (src_bits > tsmd_pkg::SRC_MAX) ? tsmd_pkg::SRC_MAX : src_bits;
    assign src_mask = (17'd1 << sb) - 17'd1;
    assign src_val  = field.bits[tsmd_pkg::SRC_W-1:0] & src_mask[tsmd_pkg::SRC_W-1:0];
    assign shifted  = field.bits >> sb;

    always_comb
    begin
        open_next  = open_reg;
        acc_next   = acc_reg;
        fidx_next  = fidx_reg;
        movf_next  = movf_reg;
        flags_next = flags_reg;
        src_next   = src_reg;
        tag_next   = tag_reg;
        data_next  = data_reg;
        stamp_next = stamp_reg;
        emit       = 1'b0;
        if (beat)
        begin
            if (!open_reg)
            begin
                if (marker == tsmd_pkg::MARK_NONE)
                begin
                    open_next  = 1'b1;
                    movf_next  = 1'b0;
                    fidx_next  = tsmd_pkg::FIELD_SRC;
                    flags_next = '0;
                    src_next   = '0;
                    tag_next   = '0;
                    data_next  = '0;
                    stamp_next = '0;
                    acc_next   = (pay == tsmd_pkg::CODE_DAQ);
                end
            end
            else if (marker != tsmd_pkg::MARK_NONE)
            begin
                if (acc_reg)
                begin
                    priority if (field.ovf)
                    begin
                        movf_next = 1'b1;
                    end
                    else if (fidx_reg == tsmd_pkg::FIELD_SRC)
                    begin
                        if (sb != '0)
                        begin
                            flags_next[0] = 1'b1;
                            src_next      = src_val;
                        end
                        tag_next = shifted[tsmd_pkg::TAG_W-1:0];
                    end
                    else if (fidx_reg == tsmd_pkg::FIELD_DATA)
                    begin
                        data_next = field.bits[tsmd_pkg::DATA_W-1:0];
                    end
                    else if (fidx_reg == tsmd_pkg::FIELD_STAMP)
                    begin
                        flags_next[1] = 1'b1;
                        stamp_next    = field.bits[tsmd_pkg::STAMP_W-1:0];
                    end
                    else
                    begin
                        // fields past the third carry nothing
                    end
                end
                if (marker[tsmd_pkg::END_FIELD_BIT] && fidx_reg != tsmd_pkg::FIELD_MAX)
                begin
                    fidx_next = fidx_reg + 1'b1;
                end
                if (marker[tsmd_pkg::END_MSG_BIT])
                begin
                    if (acc_reg)
                    begin
                        acc_next = 1'b0;
                        emit     = (fidx_next == tsmd_pkg::FIELD_STAMP ||
                                    fidx_next == tsmd_pkg::FIELD_LAST) && !movf_next;
                    end
                    open_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        rv_next = rv_reg;
        if (res_take)
        begin
            rv_next = 1'b0;
        end
        if (beat && emit)
        begin
            rv_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            acc_reg   <= 1'b0;
            fidx_reg  <= '0;
            movf_reg  <= 1'b0;
            flags_reg <= '0;
            src_reg   <= '0;
            tag_reg   <= '0;
            data_reg  <= '0;
            stamp_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            acc_reg   <= acc_next;
            fidx_reg  <= fidx_next;
            movf_reg  <= movf_next;
            flags_reg <= flags_next;
            src_reg   <= src_next;
            tag_reg   <= tag_next;
            data_reg  <= data_next;
            stamp_reg <= stamp_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat && emit)
        begin
            r_src_vld_reg   <= flags_next[0];
            r_src_reg       <= src_next;
            r_tag_reg       <= tag_next;
            r_data_reg      <= data_next;
            r_stamp_vld_reg <= flags_next[1];
            r_stamp_reg     <= stamp_next;
        end
    end

    assign msg_open      = open_reg;
    assign res_valid     = rv_reg;
    assign res_src_vld   = r_src_vld_reg;
    assign res_src       = r_src_reg;
    assign res_tag       = r_tag_reg;
    assign res_data      = r_data_reg;
    assign res_stamp_vld = r_stamp_vld_reg;
    assign res_stamp     = r_stamp_reg;

endmodule

`default_nettype wire

### rtl/trace_slice_message_decoder.sv
`default_nettype none

// Trace slice message decoder. Takes one slice byte per beat (bits 1:0 end marker,
// bits 7:2 payload) and returns one result beat for every well-formed data
// acquisition message (code 7, two or three fields, no field overflow): source
// (valid only when source_bits is nonzero), id tag, data and optional timestamp. A
// slice is held in the input register and is decoded into the result register
// when it advances; a result held by out_stall keeps it there. One slice per
// clock is sustained while no result is held by out_stall; in_stall rises only
// while the input register is full and a result is held by out_stall.
// source_bits is written by cfg_wr_en and must only change while the block is idle.
module trace_slice_message_decoder #(
    parameter int FIELD_BUFFER_BYTES = tsmd_pkg::FIELD_BUFFER_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tsmd_pkg::SRC_BITS_W-1:0] cfg_wr_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [tsmd_pkg::BYTE_W-1:0]     slice_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 source_valid,
    output logic [tsmd_pkg::SRC_W-1:0]           source_id,
    output logic [tsmd_pkg::TAG_W-1:0]           ident_tag,
    output logic [tsmd_pkg::DATA_W-1:0]          acq_data,
    output logic                                 stamp_valid,
    output logic [tsmd_pkg::STAMP_W-1:0]         stamp_value
);

    logic [tsmd_pkg::SRC_BITS_W-1:0] src_bits_reg;
    logic                            in_vld_reg, in_vld_next;
    logic [tsmd_pkg::BYTE_W-1:0]     in_byte_reg;
    logic                            advance;
    logic                            in_take;
    logic                            res_take;
    logic                            msg_open;
    tsmd_pkg::field_t                field;

    assign res_take = out_valid && !out_stall;
    assign advance  = in_vld_reg && (!out_valid || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (advance)
        begin
            in_vld_next = 1'b0;
        end
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            src_bits_reg <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_wr_en)
            begin
                src_bits_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= slice_byte;
        end
    end

    tsmd_field_buf #(
        .FIELD_BUFFER_BYTES(FIELD_BUFFER_BYTES)
    ) u_field_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (advance),
        .msg_open (msg_open),
        .slice    (in_byte_reg),
        .field    (field)
    );

    tsmd_msg_ctrl u_msg_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .beat          (advance),
        .slice         (in_byte_reg),
        .field         (field),
        .src_bits      (src_bits_reg),
        .res_take      (res_take),
        .msg_open      (msg_open),
        .res_valid     (out_valid),
        .res_src_vld   (source_valid),
        .res_src       (source_id),
        .res_tag       (ident_tag),
        .res_data      (acq_data),
        .res_stamp_vld (stamp_valid),
        .res_stamp     (stamp_value)
    );

endmodule

`default_nettype wire

### rtl/tsmd_checker.sv
`default_nettype none

`include "assert_macros.svh"

module tsmd_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tsmd_pkg::SRC_BITS_W-1:0] cfg_wr_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [tsmd_pkg::BYTE_W-1:0]     slice_byte,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic                            source_valid,
    input  wire logic [tsmd_pkg::SRC_W-1:0]      source_id,
    input  wire logic [tsmd_pkg::TAG_W-1:0]      ident_tag,
    input  wire logic [tsmd_pkg::DATA_W-1:0]     acq_data,
    input  wire logic                            stamp_valid,
    input  wire logic [tsmd_pkg::STAMP_W-1:0]    stamp_value
);

    // Input backpressure only comes from a held result.
    `TSMD_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall,
                      "in_stall without held result")

    `TSMD_ASSERT_SAME(a_src_zero, out_valid && !source_valid, source_id == '0,
                      "source_id set without source")

    `TSMD_ASSERT_SAME(a_stamp_zero, out_valid && !stamp_valid, stamp_value == '0,
                      "stamp_value set without stamp")

    `TSMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                      out_valid && $stable(ident_tag) && $stable(acq_data)
                      && $stable(stamp_value),
                      "stalled result beat changed")

endmodule

bind trace_slice_message_decoder tsmd_checker u_tsmd_checker (.*);

`default_nettype wire
